### rtl/kmpq_pkg.sv
// shared constants, payload types and the row ordering function of the merge queue
package kmpq_pkg;

   localparam int NUM_SOURCES   = 64;
   localparam int NUM_KEYS      = 4;
   localparam int KEY_WIDTH     = 32;
   localparam int PAYLOAD_WIDTH = 32;

   localparam int SRC_W         = 6;
   localparam int FIELD_W       = 32;
   localparam int IN_KEY_FIELDS = 4;
   localparam int RANK_W        = $clog2(NUM_SOURCES);
   localparam int CNT_W         = $clog2(NUM_SOURCES + 1);

   localparam int KC_W       = 3;
   localparam int DM_W       = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DESC_MASK = 1'b1;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_TAKE   = 1'b1;

   localparam logic [1:0] MODE_HOLD   = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_TAKE   = 2'd2;
   localparam logic [1:0] MODE_SORT   = 2'd3;

   typedef struct packed {
      logic               cmd;
      logic [SRC_W-1:0]   source;
      logic [FIELD_W-1:0] key_0;
      logic [FIELD_W-1:0] key_1;
      logic [FIELD_W-1:0] key_2;
      logic [FIELD_W-1:0] key_3;
      logic [FIELD_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [SRC_W-1:0]   out_source;
      logic [FIELD_W-1:0] out_key_0;
      logic [FIELD_W-1:0] out_key_1;
      logic [FIELD_W-1:0] out_key_2;
      logic [FIELD_W-1:0] out_key_3;
      logic [FIELD_W-1:0] out_payload;
      logic               was_empty;
      logic               now_empty;
   } rsp_type;

   // rank is the row's place in insertion order among the stored rows
   typedef struct packed {
      logic [SRC_W-1:0]                   source;
      logic [NUM_KEYS-1:0][KEY_WIDTH-1:0] keys;
      logic [PAYLOAD_WIDTH-1:0]           payload;
      logic [RANK_W-1:0]                  rank;
   } row_type;

   typedef struct packed {
      logic [1:0]      mode;
      logic            phase;
      logic [RANK_W-1:0] take_rank;
      logic [KC_W-1:0] key_count;
      logic [DM_W-1:0] desc_mask;
   } ctl_type;

   // true when row a leaves before row b
   function automatic logic row_before(row_type a, row_type b,
                                       logic [KC_W-1:0] kc, logic [DM_W-1:0] dm);
      int   n;
      logic done;
      logic res;
      logic desc;
      n    = int'(kc);
      done = 1'b0;
      res  = 1'b0;
      desc = 1'b0;
      if (n < 1) n = 1;
      if (n > NUM_KEYS) n = NUM_KEYS;
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (!done && (k < n) && (a.keys[k] != b.keys[k])) begin
            done = 1'b1;
            desc = (k < DM_W) ? dm[k % DM_W] : 1'b0;
            res  = desc ? (a.keys[k] > b.keys[k]) : (a.keys[k] < b.keys[k]);
         end
      end
      if (!done) begin
         if (a.source != b.source) res = a.source < b.source;
         else res = a.rank < b.rank;
      end
      return res;
   endfunction

endpackage

### rtl/kmpq_cell.sv
// one slot of the sorted row chain: insert, shift-up on take, neighbour swap on reorder
module kmpq_cell (
   input  logic              clock,
   input  logic              reset,
   input  kmpq_pkg::ctl_type ctl,
   input  logic              is_odd,
   input  kmpq_pkg::row_type new_row,
   input  kmpq_pkg::row_type prev_row,
   input  logic              prev_valid,
   input  logic              prev_keep,
   input  logic              prev_swap,
   input  kmpq_pkg::row_type right_row,
   input  logic              next_valid,
   output kmpq_pkg::row_type row,
   output logic              valid,
   output logic              keep,
   output logic              swap
);
   import kmpq_pkg::*;

   row_type row_ff, row_in;
   row_type cmp_a, cmp_b;
   logic    valid_ff, valid_in;
   logic    leads;
   logic    is_left;

   assign is_left = (is_odd == ctl.phase);

   // one comparator: against the new row on insert, against the right neighbour on reorder
   always_comb begin
      if (ctl.mode == MODE_SORT) begin
         cmp_a = right_row;
         cmp_b = row_ff;
      end else begin
         cmp_a = row_ff;
         cmp_b = new_row;
      end
      leads = row_before(cmp_a, cmp_b, ctl.key_count, ctl.desc_mask);
   end

   assign keep = valid_ff & leads;
   assign swap = (ctl.mode == MODE_SORT) & is_left & valid_ff & next_valid & leads;

   always_comb begin
      row_in   = row_ff;
      valid_in = valid_ff;
      unique case (ctl.mode)
         MODE_INSERT: begin
            if (!keep) begin
               if (prev_keep) begin
                  row_in   = new_row;
                  valid_in = 1'b1;
               end else begin
                  row_in   = prev_row;
                  valid_in = prev_valid;
               end
            end
         end
         MODE_TAKE: begin
            row_in   = right_row;
            valid_in = next_valid;
            // close the gap left in insertion order by the removed row
            if (right_row.rank > ctl.take_rank) row_in.rank = right_row.rank - 1'b1;
         end
         MODE_SORT: begin
            if (swap) row_in = right_row;
            else if (!is_left && prev_swap) row_in = prev_row;
         end
         MODE_HOLD: begin
            row_in   = row_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   assign row   = row_ff;
   assign valid = valid_ff;

endmodule

### rtl/kway_merge_priority_queue.sv
// k-way merge priority queue: sorted chain of row cells with result register
// Rows sit in a chain of NUM_SOURCES (64) cells kept sorted, the next to leave first.
// An insert item is placed by every cell comparing itself to the new row, and the
// rows that leave after it move one cell down; a take item removes the head row and
// its result is registered in the result register. The queue takes the next item as
// soon as the last one is placed, while the order is settled. Every configuration
// write changes the ordering and starts a reorder pass of odd-even neighbour swaps
// along the chain; req_stall is high through that pass. A take also waits while an
// earlier result is still held by a stalled consumer; inserts go on meanwhile.
module kway_merge_priority_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  kmpq_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output kmpq_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [kmpq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kmpq_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import kmpq_pkg::*;

   logic [KC_W-1:0]  key_count_ff, key_count_in;
   logic [DM_W-1:0]  desc_mask_ff, desc_mask_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] sort_cnt_ff, sort_cnt_in;
   logic             phase_ff, phase_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic    busy;
   logic    full;
   logic    accept;
   logic    insert_go;
   logic    take_go;
   ctl_type ctl;
   row_type new_row;

   row_type                cell_row   [NUM_SOURCES];
   logic [NUM_SOURCES-1:0] cell_valid;
   logic [NUM_SOURCES-1:0] cell_keep;
   logic [NUM_SOURCES-1:0] cell_swap;

   function automatic logic [KEY_WIDTH-1:0] in_key(req_type r, int k);
      logic [FIELD_W-1:0] f;
      unique case (k)
         0: f = r.key_0;
         1: f = r.key_1;
         2: f = r.key_2;
         3: f = r.key_3;
         default: f = '0;
      endcase
      return KEY_WIDTH'(f);
   endfunction

   function automatic logic [FIELD_W-1:0] out_key(row_type r, int k);
      logic [FIELD_W-1:0] f;
      f = '0;
      if (k < NUM_KEYS) f = FIELD_W'(r.keys[k % NUM_KEYS]);
      return f;
   endfunction

   assign busy      = (sort_cnt_ff != '0);
   assign full      = (fill_ff == CNT_W'(NUM_SOURCES));
   assign req_stall = busy | ((req_data.cmd == CMD_TAKE) & rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;
   assign insert_go = accept & (req_data.cmd == CMD_INSERT) & ~full;
   assign take_go   = accept & (req_data.cmd == CMD_TAKE);

   always_comb begin
      new_row.source  = req_data.source;
      new_row.payload = PAYLOAD_WIDTH'(req_data.payload);
      new_row.rank    = fill_ff[RANK_W-1:0];
      for (int k = 0; k < NUM_KEYS; k++) begin
         new_row.keys[k] = (k < IN_KEY_FIELDS) ? in_key(req_data, k) : '0;
      end
   end

   always_comb begin
      ctl.phase     = phase_ff;
      ctl.take_rank = cell_row[0].rank;
      ctl.key_count = key_count_ff;
      ctl.desc_mask = desc_mask_ff;
      priority if (busy) ctl.mode = MODE_SORT;
      else if (insert_go) ctl.mode = MODE_INSERT;
      else if (take_go && cell_valid[0]) ctl.mode = MODE_TAKE;
      else ctl.mode = MODE_HOLD;
   end

   for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_cell
      row_type prev_row, right_row;
      logic    prev_valid, prev_keep, prev_swap, next_valid;

      if (i == 0) begin : g_head
         assign prev_row   = '0;
         assign prev_valid = 1'b0;
         assign prev_keep  = 1'b1;
         assign prev_swap  = 1'b0;
      end else begin : g_mid
         assign prev_row   = cell_row[i-1];
         assign prev_valid = cell_valid[i-1];
         assign prev_keep  = cell_keep[i-1];
         assign prev_swap  = cell_swap[i-1];
      end

      if (i == NUM_SOURCES - 1) begin : g_tail
         assign right_row  = '0;
         assign next_valid = 1'b0;
      end else begin : g_body
         assign right_row  = cell_row[i+1];
         assign next_valid = cell_valid[i+1];
      end

      kmpq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .is_odd     (1'(i % 2)),
         .new_row    (new_row),
         .prev_row   (prev_row),
         .prev_valid (prev_valid),
         .prev_keep  (prev_keep),
         .prev_swap  (prev_swap),
         .right_row  (right_row),
         .next_valid (next_valid),
         .row        (cell_row[i]),
         .valid      (cell_valid[i]),
         .keep       (cell_keep[i]),
         .swap       (cell_swap[i])
      );
   end

   always_comb begin
      key_count_in = key_count_ff;
      desc_mask_in = desc_mask_ff;
      sort_cnt_in  = sort_cnt_ff;
      phase_in     = phase_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_COUNT: key_count_in = csr_wdata[KC_W-1:0];
            CSR_DESC_MASK: desc_mask_in = csr_wdata[DM_W-1:0];
         endcase
         sort_cnt_in = CNT_W'(NUM_SOURCES);
         phase_in    = 1'b0;
      end else if (busy) begin
         sort_cnt_in = sort_cnt_ff - 1'b1;
         phase_in    = ~phase_ff;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (insert_go) fill_in = fill_ff + 1'b1;
      else if (take_go && cell_valid[0]) fill_in = fill_ff - 1'b1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (take_go) begin
         rsp_valid_in = 1'b1;
         if (cell_valid[0]) begin
            rsp_data_in.out_source  = cell_row[0].source;
            rsp_data_in.out_key_0   = out_key(cell_row[0], 0);
            rsp_data_in.out_key_1   = out_key(cell_row[0], 1);
            rsp_data_in.out_key_2   = out_key(cell_row[0], 2);
            rsp_data_in.out_key_3   = out_key(cell_row[0], 3);
            rsp_data_in.out_payload = FIELD_W'(cell_row[0].payload);
            rsp_data_in.was_empty   = 1'b0;
            rsp_data_in.now_empty   = ~cell_valid[1];
         end else begin
            rsp_data_in           = '0;
            rsp_data_in.was_empty = 1'b1;
            rsp_data_in.now_empty = 1'b1;
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= KC_W'(1);
         desc_mask_ff <= '0;
         fill_ff      <= '0;
         sort_cnt_ff  <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_count_ff <= key_count_in;
         desc_mask_ff <= desc_mask_in;
         fill_ff      <= fill_in;
         sort_cnt_ff  <= sort_cnt_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // occupied cells always form the front of the chain
   a_fill_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == 32'(fill_ff))
      else $error("fill count disagrees with occupied cells");

   a_head_when_filled: assert property (@(posedge clock) disable iff (reset)
      cell_valid[0] == (fill_ff != '0))
      else $error("head cell occupancy disagrees with fill count");

   a_head_is_smallest: assert property (@(posedge clock) disable iff (reset)
      !busy && cell_valid[1] |->
         row_before(cell_row[0], cell_row[1], key_count_ff, desc_mask_ff))
      else $error("head row out of order");

   a_take_gives_result: assert property (@(posedge clock) disable iff (reset)
      take_go |=> rsp_valid_ff)
      else $error("take without result");

   a_config_reorders: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> busy && req_stall)
      else $error("configuration write did not start reorder pass");

endmodule

### dv/kway_merge_priority_queue_checker.sv
// checker for the merge queue: predicts every take from a model of the stored rows and compares
module kway_merge_priority_queue_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  kmpq_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  kmpq_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [kmpq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kmpq_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatches,
   output int                              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import kmpq_pkg::*;

   typedef struct packed {
      logic [SRC_W-1:0]                   source;
      logic [NUM_KEYS-1:0][KEY_WIDTH-1:0] keys;
      logic [PAYLOAD_WIDTH-1:0]           payload;
   } held_row_type;

   // rows kept in insertion order, the oldest at index 0
   held_row_type    stored_rows[NUM_SOURCES];
   int              stored_count;
   logic [KC_W-1:0] key_count_q;
   logic [DM_W-1:0] desc_mask_q;
   rsp_type         due_takes[$];
   rsp_type         oldest_take;

   function automatic bit leaves_first(held_row_type a, held_row_type b);
      int n;
      bit desc;
      n = int'(key_count_q);
      if (n < 1) n = 1;
      if (n > NUM_KEYS) n = NUM_KEYS;
      for (int i = 0; i < n; i++) begin
         if (a.keys[i] != b.keys[i]) begin
            desc = (i < DM_W) && desc_mask_q[i];
            return desc ? (a.keys[i] > b.keys[i]) : (a.keys[i] < b.keys[i]);
         end
      end
      // full key tie: lower source first, then the earlier insert (lower index)
      return a.source < b.source;
   endfunction

   task automatic merge_step(input req_type item);
      held_row_type fresh;
      rsp_type      due;
      int           best;
      if (item.cmd == CMD_INSERT) begin
         // a full store drops the row
         if (stored_count < NUM_SOURCES) begin
            fresh.source  = item.source;
            fresh.keys[0] = item.key_0;
            fresh.keys[1] = item.key_1;
            fresh.keys[2] = item.key_2;
            fresh.keys[3] = item.key_3;
            fresh.payload = item.payload;
            stored_rows[stored_count] = fresh;
            stored_count++;
         end
      end else begin
         due = '0;
         if (stored_count == 0) begin
            due.was_empty = 1'b1;
            due.now_empty = 1'b1;
         end else begin
            best = 0;
            for (int i = 1; i < stored_count; i++)
               if (leaves_first(stored_rows[i], stored_rows[best])) best = i;
            due.out_source  = stored_rows[best].source;
            due.out_key_0   = stored_rows[best].keys[0];
            due.out_key_1   = stored_rows[best].keys[1];
            due.out_key_2   = stored_rows[best].keys[2];
            due.out_key_3   = stored_rows[best].keys[3];
            due.out_payload = stored_rows[best].payload;
            for (int i = best; i + 1 < stored_count; i++)
               stored_rows[i] = stored_rows[i + 1];
            stored_count--;
            due.now_empty = (stored_count == 0);
         end
         due_takes.push_back(due);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stored_count = 0;
         key_count_q  = 3'd1;
         desc_mask_q  = '0;
         mismatches   = 0;
         due_takes.delete();
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_KEY_COUNT: key_count_q = csr_wdata[KC_W-1:0];
               CSR_DESC_MASK: desc_mask_q = csr_wdata[DM_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) merge_step(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (due_takes.size() == 0) begin
               $error("result item with no take outstanding: source %0h payload %0h",
                      rsp_data.out_source, rsp_data.out_payload);
               mismatches++;
            end else begin
               oldest_take = due_takes.pop_front();
               check_field("out_source", 32'(oldest_take.out_source), 32'(rsp_data.out_source));
               check_field("out_key_0", oldest_take.out_key_0, rsp_data.out_key_0);
               check_field("out_key_1", oldest_take.out_key_1, rsp_data.out_key_1);
               check_field("out_key_2", oldest_take.out_key_2, rsp_data.out_key_2);
               check_field("out_key_3", oldest_take.out_key_3, rsp_data.out_key_3);
               check_field("out_payload", oldest_take.out_payload, rsp_data.out_payload);
               check_field("was_empty", 32'(oldest_take.was_empty), 32'(rsp_data.was_empty));
               check_field("now_empty", 32'(oldest_take.now_empty), 32'(rsp_data.now_empty));
            end
         end
         outstanding <= due_takes.size();
      end
   end

endmodule

### dv/kway_merge_priority_queue_tb.sv
// testbench top for the merge queue: clock, reset, stimulus, receiver stalls and verdict
module kway_merge_priority_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import kmpq_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 160;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_KEY_COUNT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatches;
   int outstanding;
   int send_idle   = 38;
   int recv_idle   = 51;
   int quiet_count = 0;

   kway_merge_priority_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   kway_merge_priority_queue_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   // watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_count <= 0;
      else
         quiet_count <= quiet_count + 1;
      if (quiet_count >= QUIET_LIMIT) begin
         $display("kway_merge_priority_queue_tb: errors");
         $finish;
      end
   end

   // small values often, so that keys tie and the later keys decide
   function automatic logic [FIELD_W-1:0] pick_key();
      case ($urandom_range(9))
         0, 1, 2, 3: return FIELD_W'($urandom_range(3));
         4: return '0;
         5: return '1;
         default: return FIELD_W'($urandom);
      endcase
   endfunction

   function automatic req_type random_row(logic cmd);
      req_type r;
      r.cmd     = cmd;
      r.source  = ($urandom_range(3) == 0) ? SRC_W'($urandom_range(3))
                                           : SRC_W'($urandom_range(63));
      r.key_0   = pick_key();
      r.key_1   = pick_key();
      r.key_2   = pick_key();
      r.key_3   = pick_key();
      r.payload = FIELD_W'($urandom);
      return r;
   endfunction

   function automatic req_type insert_row(logic [SRC_W-1:0] src, logic [FIELD_W-1:0] k0,
                                          logic [FIELD_W-1:0] k1, logic [FIELD_W-1:0] pay);
      req_type r;
      r = random_row(CMD_INSERT);
      r.source  = src;
      r.key_0   = k0;
      r.key_1   = k1;
      r.payload = pay;
      return r;
   endfunction

   task automatic send(input req_type item);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      wait_drained();
      // an insert may still be settling, and an earlier write may still be reordering
      repeat (8) @(posedge clock);
      while (req_stall) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] kc_plan[PHASES];
      logic [CSR_DATA_W-1:0] dm_plan[PHASES];
      int   rows_held;
      int   burst_left;
      logic burst_cmd;
      logic cmd;
      kc_plan = '{4'd4, 4'd0, 4'd7, 4'hA, 4'd3, 4'd4, 4'd1, 4'hC};
      dm_plan = '{4'hF, 4'h0, 4'hA, 4'h5, 4'hC, 4'h0, 4'hF, 4'h0};
      rows_held  = 0;
      burst_left = 0;
      burst_cmd  = CMD_INSERT;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one key ascending: empty take, extremes, source tie break, full tie in insert order
      send(random_row(CMD_TAKE));
      send(insert_row(6'd63, '1, '1, '1));
      send(insert_row(6'd0, '0, '0, '0));
      send(insert_row(6'd5, 32'd7, 32'd1, 32'h0000_000A));
      send(insert_row(6'd3, 32'd7, 32'd2, 32'h0000_000B));
      send(insert_row(6'd3, 32'd7, 32'd2, 32'h0000_000C));
      repeat (6) send(random_row(CMD_TAKE));

      // second key decides and sorts descending
      write_csr(CSR_KEY_COUNT, 4'd2);
      write_csr(CSR_DESC_MASK, 4'b0010);
      send(insert_row(6'd1, 32'd5, 32'd1, 32'h1111_1111));
      send(insert_row(6'd2, 32'd5, 32'd9, 32'h2222_2222));
      send(insert_row(6'd0, 32'd6, 32'd0, 32'h3333_3333));
      repeat (3) send(random_row(CMD_TAKE));

      for (int p = 0; p < PHASES; p++) begin
         send_idle = (p < 3) ? 38 : (p < 6) ? 51 : 0;
         recv_idle = (p < 3) ? 51 : (p < 6) ? 38 : 0;
         write_csr(CSR_KEY_COUNT, kc_plan[p]);
         write_csr(CSR_DESC_MASK, (p == PHASES - 1) ? CSR_DATA_W'($urandom_range(15))
                                                    : dm_plan[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) wait_drained();
            if (burst_left > 0) begin
               cmd = burst_cmd;
               burst_left--;
            end else if ($urandom_range(99) < 4) begin
               // long run of one command: fills past full or drains past empty
               burst_cmd  = $urandom_range(1) ? CMD_TAKE : CMD_INSERT;
               burst_left = $urandom_range(20, 70);
               cmd        = burst_cmd;
            end else if (rows_held < 4) begin
               cmd = ($urandom_range(3) == 0) ? CMD_TAKE : CMD_INSERT;
            end else begin
               cmd = $urandom_range(1) ? CMD_TAKE : CMD_INSERT;
            end
            send(random_row(cmd));
            if (cmd == CMD_INSERT) rows_held = (rows_held < NUM_SOURCES) ? rows_held + 1
                                                                           : rows_held;
            else rows_held = (rows_held > 0) ? rows_held - 1 : 0;
         end
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("kway_merge_priority_queue_tb: clean");
      else
         $display("kway_merge_priority_queue_tb: errors");
      $finish;
   end

endmodule

### sim.f
rtl/kmpq_pkg.sv
rtl/kmpq_cell.sv
rtl/kway_merge_priority_queue.sv
dv/kway_merge_priority_queue_checker.sv
dv/kway_merge_priority_queue_tb.sv
